[sv/round_robin_task_ring_macros.svh]
// Assertion macros for the round-robin task ring.
// Uses the clk and rst_n signals of the module that includes it.
`ifndef ROUND_ROBIN_TASK_RING_MACROS_SVH
`define ROUND_ROBIN_TASK_RING_MACROS_SVH
`ifndef SYNTHESIS
`define RRTR_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("task ring same-cycle check failed");
`define RRTR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("task ring next-cycle check failed");
`else
`define RRTR_ASSERT_IMPLIES(lbl, ante, cons)
`define RRTR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[sv/rrtr_pkg.sv]
// Shared types and constants for the round-robin task ring.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package rrtr_pkg;

  localparam int OP_W          = 3;
  localparam int SLOT_W        = 3;
  localparam int BUSY_W        = 3;
  localparam int TASK_ID_MAX_W = 6;

  typedef enum logic [OP_W-1:0] {
    OP_YIELD   = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_RELEASE = 3'd2,
    OP_LAUNCH  = 3'd3,
    OP_FINISH  = 3'd4,
    OP_QUERY   = 3'd5
  } op_t;

endpackage

`default_nettype wire

[sv/rrtr_channels.sv]
// Valid/ready channel interfaces for the round-robin task ring.
// Depends on rrtr_pkg for the field widths.
`default_nettype none

interface rrtr_in_if;
  logic                            valid;
  logic                            ready;
  logic [rrtr_pkg::OP_W-1:0]       op;
  logic [rrtr_pkg::SLOT_W-1:0]     slot;

  modport source (output valid, output op, output slot, input ready);
  modport sink   (input valid, input op, input slot, output ready);
endinterface

interface rrtr_out_if;
  logic                            valid;
  logic                            ready;
  logic                            switched;
  logic [rrtr_pkg::SLOT_W-1:0]     now_task;
  logic                            fresh_start;
  logic [rrtr_pkg::SLOT_W-1:0]     granted_slot;
  logic                            grant_ok;
  logic                            slot_busy;
  logic [rrtr_pkg::BUSY_W-1:0]     busy_apps;
  logic                            app_active;

  modport source (output valid, output switched, output now_task, output fresh_start,
                  output granted_slot, output grant_ok, output slot_busy,
                  output busy_apps, output app_active, input ready);
  modport sink   (input valid, input switched, input now_task, input fresh_start,
                  input granted_slot, input grant_ok, input slot_busy,
                  input busy_apps, input app_active, output ready);
endinterface

`default_nettype wire

[sv/round_robin_task_ring.sv]
// Round-robin task ring top level; depends on rrtr_pkg, rrtr_channels and the macro header.
// A result is registered and becomes valid in the cycle after its op transfer is accepted.
// Throughput: one op per cycle; the ring state and result register update in the same
// cycle, so a new op is taken whenever the result register is empty or being drained.
// Reset (synchronous, active low): task 0 runnable and current, no saved contexts,
// result register empty.
`default_nettype none
`include "round_robin_task_ring_macros.svh"

module round_robin_task_ring #(
  parameter int TASK_COUNT = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  rrtr_in_if.sink       in_ch,
  rrtr_out_if.source    out_ch
);

  localparam int ID_W = (TASK_COUNT > 2) ? $clog2(TASK_COUNT) : 1;

  typedef logic [TASK_COUNT-1:0] vec_t;
  typedef logic [ID_W-1:0]       id_t;

  // Ring state. Bit 0 of ready_r never clears: task 0 is always runnable.
  // app_cnt_r tracks the number of runnable app slots so no popcount is needed.
  vec_t ready_r, ready_nxt;
  vec_t saved_r, saved_nxt;
  id_t  cur_r, cur_nxt;
  id_t  app_cnt_r, app_cnt_nxt;

  // Result register.
  logic                            out_valid_r;
  logic                            out_sw_r, sw_nxt;
  logic [rrtr_pkg::SLOT_W-1:0]     out_now_r, now_nxt;
  logic                            out_fresh_r, fresh_nxt;
  logic [rrtr_pkg::SLOT_W-1:0]     out_granted_r, granted_nxt;
  logic                            out_ok_r, ok_nxt;
  logic                            out_busy_r, busy_nxt;
  logic [rrtr_pkg::BUSY_W-1:0]     out_busy_apps_r, busy_apps_nxt;
  logic                            out_app_r, app_nxt;

  logic accept;
  logic in_ready;
  rrtr_pkg::op_t op;

  // Decoded slot and current-task vectors.
  vec_t slot_oh;
  vec_t me_oh;
  vec_t above_me;
  logic slot_in_range;
  logic slot_is_me;
  logic me_is_zero;
  vec_t fin_clear;

  // Round-robin search, shared by yield and finish.
  vec_t search_vec;
  vec_t search_hi;
  vec_t search_pick;
  vec_t tgt_oh;
  id_t  tgt_id;
  logic tgt_switch;
  logic tgt_saved;

  // First-free search for allocate.
  vec_t free_vec;
  vec_t free_oh;
  id_t  grant_id;
  logic grant_found;

  id_t  gr_id;
  logic [rrtr_pkg::TASK_ID_MAX_W-1:0] cnt_wide;

  // The result register is parted from the input side: a new op is taken while
  // the present result is being transferred out.
  assign in_ready    = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;
  assign op          = rrtr_pkg::op_t'(in_ch.op);

  // One-hot decode of the slot field (slot 0 never counts as in range), of the
  // current task, and a mask of every task numbered above the current one.
  always_comb begin
    for (int i = 0; i < TASK_COUNT; i++) begin
      slot_oh[i]  = (i != 0) && (int'(in_ch.slot) == i);
      me_oh[i]    = (int'(cur_r) == i);
      above_me[i] = (i > int'(cur_r));
    end
  end

  assign slot_in_range = |slot_oh;
  assign slot_is_me    = |(slot_oh & me_oh);
  assign me_is_zero    = (cur_r == '0);
  // Finish releases the current task unless it is task 0.
  assign fin_clear     = me_is_zero ? '0 : me_oh;

  // Next runnable task after the current one, wrapping round the ring. Tasks
  // above the current one win; otherwise the lowest runnable task is taken,
  // which may be the current task itself (then nothing switches).
  assign search_vec  = (op == rrtr_pkg::OP_FINISH) ? (ready_r & ~fin_clear) : ready_r;
  assign search_hi   = search_vec & above_me;
  assign search_pick = (|search_hi) ? search_hi : search_vec;
  assign tgt_oh      = search_pick & (~search_pick + vec_t'(1));
  assign tgt_switch  = (|search_pick) && (tgt_id != cur_r);
  assign tgt_saved   = |(tgt_oh & saved_r);

  // Lowest app slot that is not runnable.
  assign free_vec    = ~ready_r & ~vec_t'(1);
  assign free_oh     = free_vec & (~free_vec + vec_t'(1));
  assign grant_found = |free_vec;

  // One-hot to index encoders.
  always_comb begin
    tgt_id   = '0;
    grant_id = '0;
    for (int i = 0; i < TASK_COUNT; i++) begin
      if (tgt_oh[i]) begin
        tgt_id = tgt_id | id_t'(i);
      end
      if (free_oh[i]) begin
        grant_id = grant_id | id_t'(i);
      end
    end
  end

  // Per-op state update and result.
  always_comb begin
    ready_nxt   = ready_r;
    saved_nxt   = saved_r;
    cur_nxt     = cur_r;
    app_cnt_nxt = app_cnt_r;
    sw_nxt      = 1'b0;
    fresh_nxt   = 1'b0;
    ok_nxt      = 1'b0;
    gr_id       = '0;
    unique case (op)
      rrtr_pkg::OP_YIELD: begin
        if (tgt_switch) begin
          saved_nxt = saved_r | me_oh;
          cur_nxt   = tgt_id;
          sw_nxt    = 1'b1;
          fresh_nxt = !tgt_saved;
        end
      end
      rrtr_pkg::OP_ALLOC: begin
        if (grant_found) begin
          ready_nxt   = ready_r | free_oh;
          saved_nxt   = saved_r & ~free_oh;
          app_cnt_nxt = app_cnt_r + id_t'(1);
          gr_id       = grant_id;
          ok_nxt      = 1'b1;
        end
      end
      rrtr_pkg::OP_RELEASE: begin
        if (slot_in_range) begin
          ready_nxt = ready_r & ~slot_oh;
          saved_nxt = saved_r & ~slot_oh;
          if (|(slot_oh & ready_r)) begin
            app_cnt_nxt = app_cnt_r - id_t'(1);
          end
        end
      end
      rrtr_pkg::OP_LAUNCH: begin
        if (slot_in_range) begin
          ready_nxt = ready_r | slot_oh;
          // Launching the current task leaves its saved bit set.
          saved_nxt = (saved_r & ~slot_oh) | me_oh;
          if (!(|(slot_oh & ready_r))) begin
            app_cnt_nxt = app_cnt_r + id_t'(1);
          end
          if (!slot_is_me) begin
            cur_nxt   = id_t'(in_ch.slot);
            sw_nxt    = 1'b1;
            fresh_nxt = 1'b1;
          end
        end
      end
      rrtr_pkg::OP_FINISH: begin
        ready_nxt = ready_r & ~fin_clear;
        saved_nxt = saved_r & ~fin_clear;
        if (|(fin_clear & ready_r)) begin
          app_cnt_nxt = app_cnt_r - id_t'(1);
        end
        if (tgt_switch) begin
          cur_nxt   = tgt_id;
          sw_nxt    = 1'b1;
          fresh_nxt = !tgt_saved;
        end
      end
      default: begin
        // Query and the unused codes leave the ring untouched.
      end
    endcase
  end

  // Status fields, all taken from the state after the op.
  assign cnt_wide      = rrtr_pkg::TASK_ID_MAX_W'(app_cnt_nxt);
  assign busy_apps_nxt = (cnt_wide > rrtr_pkg::TASK_ID_MAX_W'(7)) ?
                         rrtr_pkg::BUSY_W'(7) : rrtr_pkg::BUSY_W'(cnt_wide);
  assign now_nxt       = rrtr_pkg::SLOT_W'(rrtr_pkg::TASK_ID_MAX_W'(cur_nxt));
  assign granted_nxt   = rrtr_pkg::SLOT_W'(rrtr_pkg::TASK_ID_MAX_W'(gr_id));
  assign busy_nxt      = |(slot_oh & ready_nxt);
  assign app_nxt       = (cur_nxt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r     <= vec_t'(1);
      saved_r     <= '0;
      cur_r       <= '0;
      app_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        ready_r     <= ready_nxt;
        saved_r     <= saved_nxt;
        cur_r       <= cur_nxt;
        app_cnt_r   <= app_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is only read while out_valid_r is set.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_sw_r        <= sw_nxt;
      out_now_r       <= now_nxt;
      out_fresh_r     <= fresh_nxt;
      out_granted_r   <= granted_nxt;
      out_ok_r        <= ok_nxt;
      out_busy_r      <= busy_nxt;
      out_busy_apps_r <= busy_apps_nxt;
      out_app_r       <= app_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.switched     = out_sw_r;
  assign out_ch.now_task     = out_now_r;
  assign out_ch.fresh_start  = out_fresh_r;
  assign out_ch.granted_slot = out_granted_r;
  assign out_ch.grant_ok     = out_ok_r;
  assign out_ch.slot_busy    = out_busy_r;
  assign out_ch.busy_apps    = out_busy_apps_r;
  assign out_ch.app_active   = out_app_r;

  // Task 0 must stay runnable whatever the op sequence.
  `RRTR_ASSERT_IMPLIES(a_task0_runnable, 1'b1, ready_r[0])
  // The running app count can never exceed the number of app slots.
  `RRTR_ASSERT_IMPLIES(a_cnt_bound, 1'b1, int'(app_cnt_r) < TASK_COUNT)
  // A fresh start is only reported together with a switch.
  `RRTR_ASSERT_IMPLIES(a_fresh_needs_switch, out_valid_r && out_fresh_r, out_sw_r)
  // Any result without a grant, such as a failed allocate, reports slot zero.
  `RRTR_ASSERT_IMPLIES(a_grant_zero, out_valid_r && !out_ok_r, out_granted_r == '0)
  // A switch always moves the current task.
  `RRTR_ASSERT_NEXT(a_switch_moves, accept && sw_nxt, cur_r != $past(cur_r))

endmodule

`default_nettype wire
